/* rtl/tcf_pkg.sv */
// Shared types and constants of the triangle tangent frame block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tcf_pkg;

    localparam int INDEX_BITS_DEFAULT = 16;
    localparam int POS_W   = 32;
    localparam int IDX_W   = 16;
    localparam int DELTA_W = POS_W + 1;
    localparam int PROD_W  = 2 * DELTA_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int NORM_W  = 30;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int DIV_W   = 48;
    localparam int Q_W     = 16;

    typedef struct packed {
        logic        [IDX_W-1:0] vertex_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [POS_W-1:0] tex_u;
        logic signed [POS_W-1:0] tex_v;
    } t_in_item;

    typedef struct packed {
        logic        [IDX_W-1:0] corner_index;
        logic signed [Q_W-1:0]   tangent_x;
        logic signed [Q_W-1:0]   tangent_y;
        logic signed [Q_W-1:0]   tangent_z;
        logic signed [Q_W-1:0]   bitangent_x;
        logic signed [Q_W-1:0]   bitangent_y;
        logic signed [Q_W-1:0]   bitangent_z;
        logic                    degenerate;
        logic                    last_of_triangle;
    } t_out_item;

    typedef struct packed {
        logic signed [DELTA_W-1:0] dp1_x;
        logic signed [DELTA_W-1:0] dp1_y;
        logic signed [DELTA_W-1:0] dp1_z;
        logic signed [DELTA_W-1:0] dp2_x;
        logic signed [DELTA_W-1:0] dp2_y;
        logic signed [DELTA_W-1:0] dp2_z;
        logic signed [DELTA_W-1:0] du1;
        logic signed [DELTA_W-1:0] dv1;
        logic signed [DELTA_W-1:0] du2;
        logic signed [DELTA_W-1:0] dv2;
    } t_tri;

endpackage

`default_nettype wire

/* rtl/triangle_tangent_frame_core.sv */
// Per-triangle tangent frame: top level joining front end, queue and back end.
// Uses tcf_pkg, tcf_front, tcf_queue and tcf_back.
//
// Usage: corners enter on the i_valid/o_ready channel, one beat per corner,
// three beats per triangle. The first two corners are held; the third pushes
// a delta record into a two-entry queue, so the front keeps taking corners
// while the back end computes. Per triangle the back end issues three beats
// on o_valid/i_ready, one per corner in arrival order, the last flagged.
// The back end takes one triangle at a time, running it through the single
// shared 33x33 multiplier (14 products, 3 squares per vector), the
// one-bit-per-cycle normalizing shifter (up to 37 steps per vector), the
// 32-step square root and six restoring divisions; a zero UV determinant
// skips all but the products and goes straight to the output beats.
// Reset clears the corner count, queue pointers, sequencer and output valid.
// A stalled receiver holds the output register; the back end then waits, the
// queue fills, and o_ready drops on the third corner of a triangle.
`timescale 1ns / 1ps
`default_nettype none

module triangle_tangent_frame_core import tcf_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    localparam int REC_W = $bits(t_tri) + 3 * INDEX_BITS;

    logic                    w_f_valid;
    logic                    w_f_ready;
    t_tri                    w_f_tri;
    logic [3*INDEX_BITS-1:0] w_f_idx;
    logic                    w_b_valid;
    logic                    w_b_ready;
    logic [REC_W-1:0]        w_b_data;
    t_tri                    w_b_tri;
    logic [3*INDEX_BITS-1:0] w_b_idx;

    tcf_front #(.INDEX_BITS(INDEX_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_tri_valid (w_f_valid),
        .i_tri_ready (w_f_ready),
        .o_tri       (w_f_tri),
        .o_tri_idx   (w_f_idx)
    );

    tcf_queue #(.WIDTH(REC_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  ({w_f_tri, w_f_idx}),
        .o_valid (w_b_valid),
        .i_ready (w_b_ready),
        .o_data  (w_b_data)
    );

    assign {w_b_tri, w_b_idx} = w_b_data;

    tcf_back #(.INDEX_BITS(INDEX_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tri_valid (w_b_valid),
        .o_tri_ready (w_b_ready),
        .i_tri       (w_b_tri),
        .i_tri_idx   (w_b_idx),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

endmodule

`default_nettype wire

/* rtl/tcf_front.sv */
// Front end: takes corner beats, holds the first two corners of a triangle
// and forms the edge and UV deltas on the third. Uses tcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcf_front import tcf_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_in_item                i_item,
    output logic                    o_tri_valid,
    input  logic                    i_tri_ready,
    output t_tri                    o_tri,
    output logic [3*INDEX_BITS-1:0] o_tri_idx
);

    logic [1:0] r_count;
    logic [1:0] n_count;
    t_in_item   r_held [2];
    logic       w_accept;
    logic       w_third;

    assign w_third     = (r_count == 2'd2);
    assign o_ready     = !w_third || i_tri_ready;
    assign w_accept    = i_valid && o_ready;
    assign o_tri_valid = i_valid && w_third;

    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            n_count = w_third ? 2'd0 : r_count + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_third) begin
            r_held[r_count[0]] <= i_item;
        end
    end

    assign o_tri.dp1_x = DELTA_W'(r_held[1].pos_x) - DELTA_W'(r_held[0].pos_x);
    assign o_tri.dp1_y = DELTA_W'(r_held[1].pos_y) - DELTA_W'(r_held[0].pos_y);
    assign o_tri.dp1_z = DELTA_W'(r_held[1].pos_z) - DELTA_W'(r_held[0].pos_z);
    assign o_tri.dp2_x = DELTA_W'(i_item.pos_x) - DELTA_W'(r_held[0].pos_x);
    assign o_tri.dp2_y = DELTA_W'(i_item.pos_y) - DELTA_W'(r_held[0].pos_y);
    assign o_tri.dp2_z = DELTA_W'(i_item.pos_z) - DELTA_W'(r_held[0].pos_z);
    assign o_tri.du1   = DELTA_W'(r_held[1].tex_u) - DELTA_W'(r_held[0].tex_u);
    assign o_tri.dv1   = DELTA_W'(r_held[1].tex_v) - DELTA_W'(r_held[0].tex_v);
    assign o_tri.du2   = DELTA_W'(i_item.tex_u) - DELTA_W'(r_held[0].tex_u);
    assign o_tri.dv2   = DELTA_W'(i_item.tex_v) - DELTA_W'(r_held[0].tex_v);

    assign o_tri_idx = {INDEX_BITS'(i_item.vertex_index),
                        INDEX_BITS'(r_held[1].vertex_index),
                        INDEX_BITS'(r_held[0].vertex_index)};

endmodule

`default_nettype wire

/* rtl/tcf_queue.sv */
// Two-entry queue of triangle records between front and back end.
// Generic over record width; uses tcf_pkg only for the default width, $bits(t_tri).
`timescale 1ns / 1ps
`default_nettype none

module tcf_queue import tcf_pkg::*; #(
    parameter int WIDTH = $bits(t_tri)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/tcf_back.sv */
// Back end: sequencer over one shared multiplier, a normalizing shifter,
// a bit-serial square root and a restoring divider. Uses tcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcf_back import tcf_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_tri_valid,
    output logic                    o_tri_ready,
    input  t_tri                    i_tri,
    input  logic [3*INDEX_BITS-1:0] i_tri_idx,
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_out_item               o_item
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SIGN, S_LOAD, S_SHIFT, S_SQ, S_SQRT, S_DIVL, S_DIV, S_OUT
    } t_state;

    t_state                   r_state;
    logic [3:0]               r_step;
    logic [1:0]               r_comp;
    logic [1:0]               r_k;
    logic [3:0]               r_it;
    logic                     r_vsel;
    logic                     r_degen;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic signed [DELTA_W-1:0] r_dp1 [3];
    logic signed [DELTA_W-1:0] r_dp2 [3];
    logic signed [DELTA_W-1:0] r_du1, r_dv1, r_du2, r_dv2;
    logic [INDEX_BITS-1:0]     r_idx [3];
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc [7];
    logic [ACC_W-1:0]          r_mag [6];
    logic                      r_neg_t [3];
    logic                      r_neg_b [3];
    logic [ACC_W-1:0]          r_c [3];
    logic [SUM_W-1:0]          r_sum;
    logic [SUM_W-1:0]          r_x;
    logic [SUM_W-1:0]          r_r;
    logic [SUM_W-1:0]          r_bit;
    logic [DIV_W-1:0]          r_rem;
    logic [DIV_W-1:0]          r_ds;
    logic [Q_W-1:0]            r_q;
    logic [Q_W-1:0]            r_tq [3];
    logic [Q_W-1:0]            r_bq [3];

    logic signed [DELTA_W-1:0] w_ma, w_mb;
    logic signed [PROD_W-1:0]  w_prod;
    logic [ACC_W-1:0]          w_csel;
    logic [ACC_W-1:0]          w_cdiv;
    logic [ACC_W-1:0]          w_or;
    logic [3:0]                w_prev;
    logic [SUM_W-1:0]          w_trial;
    logic                      w_ge;
    logic [Q_W-1:0]            w_qf;
    logic                      w_neg;
    logic [Q_W-1:0]            w_res;
    logic [INDEX_BITS-1:0]     w_idx;

    assign o_tri_ready = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_item      = r_out;

    always_comb begin
        case (r_step[1:0])
            2'd0:    w_csel = r_c[0];
            2'd1:    w_csel = r_c[1];
            default: w_csel = r_c[2];
        endcase
        case (r_comp)
            2'd0:    w_cdiv = r_c[0];
            2'd1:    w_cdiv = r_c[1];
            default: w_cdiv = r_c[2];
        endcase
        case (r_comp)
            2'd0:    w_neg = r_vsel ? r_neg_b[0] : r_neg_t[0];
            2'd1:    w_neg = r_vsel ? r_neg_b[1] : r_neg_t[1];
            default: w_neg = r_vsel ? r_neg_b[2] : r_neg_t[2];
        endcase
        case (r_k)
            2'd0:    w_idx = r_idx[0];
            2'd1:    w_idx = r_idx[1];
            default: w_idx = r_idx[2];
        endcase
    end

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == S_SQ) begin
            w_ma = $signed({3'b000, w_csel[NORM_W-1:0]});
            w_mb = $signed({3'b000, w_csel[NORM_W-1:0]});
        end else if (r_state == S_MUL) begin
            case (r_step)
                4'd0:    begin w_ma = r_du1;    w_mb = r_dv2; end
                4'd1:    begin w_ma = r_dv1;    w_mb = r_du2; end
                4'd2:    begin w_ma = r_dp1[0]; w_mb = r_dv2; end
                4'd3:    begin w_ma = r_dp2[0]; w_mb = r_dv1; end
                4'd4:    begin w_ma = r_dp1[1]; w_mb = r_dv2; end
                4'd5:    begin w_ma = r_dp2[1]; w_mb = r_dv1; end
                4'd6:    begin w_ma = r_dp1[2]; w_mb = r_dv2; end
                4'd7:    begin w_ma = r_dp2[2]; w_mb = r_dv1; end
                4'd8:    begin w_ma = r_dp2[0]; w_mb = r_du1; end
                4'd9:    begin w_ma = r_dp1[0]; w_mb = r_du2; end
                4'd10:   begin w_ma = r_dp2[1]; w_mb = r_du1; end
                4'd11:   begin w_ma = r_dp1[1]; w_mb = r_du2; end
                4'd12:   begin w_ma = r_dp2[2]; w_mb = r_du1; end
                4'd13:   begin w_ma = r_dp1[2]; w_mb = r_du2; end
                default: begin w_ma = '0;       w_mb = '0;    end
            endcase
        end
    end

    assign w_prod  = PROD_W'(w_ma) * PROD_W'(w_mb);
    assign w_prev  = r_step - 4'd1;
    assign w_or    = r_c[0] | r_c[1] | r_c[2];
    assign w_trial = r_r + r_bit;
    assign w_ge    = (r_rem >= r_ds);
    assign w_qf    = {r_q[Q_W-2:0], w_ge};
    assign w_res   = w_neg ? Q_W'(0) - w_qf : w_qf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_prod <= w_prod;
            if (i_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_tri_valid) begin
                        r_dp1[0] <= i_tri.dp1_x;
                        r_dp1[1] <= i_tri.dp1_y;
                        r_dp1[2] <= i_tri.dp1_z;
                        r_dp2[0] <= i_tri.dp2_x;
                        r_dp2[1] <= i_tri.dp2_y;
                        r_dp2[2] <= i_tri.dp2_z;
                        r_du1    <= i_tri.du1;
                        r_dv1    <= i_tri.dv1;
                        r_du2    <= i_tri.du2;
                        r_dv2    <= i_tri.dv2;
                        for (int i = 0; i < 3; i++) begin
                            r_idx[i] <= i_tri_idx[i*INDEX_BITS +: INDEX_BITS];
                        end
                        r_step   <= 4'd0;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_step != 4'd0) begin
                        if (!w_prev[0]) begin
                            r_acc[w_prev[3:1]] <= ACC_W'(r_prod);
                        end else begin
                            r_acc[w_prev[3:1]] <= r_acc[w_prev[3:1]] - ACC_W'(r_prod);
                        end
                    end
                    if (r_step == 4'd14) begin
                        r_state <= S_SIGN;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_SIGN: begin
                    r_degen <= (r_acc[0] == '0);
                    r_vsel  <= 1'b0;
                    r_k     <= 2'd0;
                    for (int j = 0; j < 6; j++) begin
                        r_mag[j] <= r_acc[j+1][ACC_W-1] ? ACC_W'(0) - r_acc[j+1] : r_acc[j+1];
                    end
                    for (int j = 0; j < 3; j++) begin
                        r_neg_t[j] <= (r_acc[j+1] != '0) &&
                                      (r_acc[j+1][ACC_W-1] ^ r_acc[0][ACC_W-1]);
                        r_neg_b[j] <= (r_acc[j+4] != '0) &&
                                      (r_acc[j+4][ACC_W-1] ^ r_acc[0][ACC_W-1]);
                    end
                    r_state <= (r_acc[0] == '0) ? S_OUT : S_LOAD;
                end
                S_LOAD: begin
                    for (int i = 0; i < 3; i++) begin
                        r_c[i] <= r_vsel ? r_mag[i+3] : r_mag[i];
                    end
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (w_or == '0) begin
                        r_degen <= 1'b1;
                        r_state <= S_OUT;
                    end else if (|w_or[ACC_W-1:NORM_W]) begin
                        for (int i = 0; i < 3; i++) begin
                            r_c[i] <= r_c[i] >> 1;
                        end
                    end else if (!w_or[NORM_W-1]) begin
                        for (int i = 0; i < 3; i++) begin
                            r_c[i] <= r_c[i] << 1;
                        end
                    end else begin
                        r_step  <= 4'd0;
                        r_sum   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_step == 4'd3) begin
                        r_x     <= r_sum + SUM_W'(r_prod);
                        r_r     <= '0;
                        r_bit   <= SUM_W'(1) << (SUM_W - 2);
                        r_state <= S_SQRT;
                    end else begin
                        if (r_step != 4'd0) begin
                            r_sum <= r_sum + SUM_W'(r_prod);
                        end
                        r_step <= r_step + 4'd1;
                    end
                end
                S_SQRT: begin
                    if (r_x >= w_trial) begin
                        r_x <= r_x - w_trial;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_comp  <= 2'd0;
                        r_state <= S_DIVL;
                    end
                end
                S_DIVL: begin
                    r_rem   <= {3'b000, w_cdiv[NORM_W-1:0], 15'd0}
                             + DIV_W'(r_r[ROOT_W-1:0]);
                    r_ds    <= {r_r[ROOT_W-1:0], 16'd0};
                    r_q     <= '0;
                    r_it    <= 4'd0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_ge) begin
                        r_rem <= r_rem - r_ds;
                    end
                    r_ds <= r_ds >> 1;
                    r_q  <= w_qf;
                    r_it <= r_it + 4'd1;
                    if (r_it == 4'd15) begin
                        if (r_vsel) begin
                            r_bq[r_comp] <= w_res;
                        end else begin
                            r_tq[r_comp] <= w_res;
                        end
                        if (r_comp == 2'd2) begin
                            if (!r_vsel) begin
                                r_vsel  <= 1'b1;
                                r_state <= S_LOAD;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_comp  <= r_comp + 2'd1;
                            r_state <= S_DIVL;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid            <= 1'b1;
                        r_out.corner_index     <= IDX_W'(w_idx);
                        r_out.tangent_x        <= r_degen ? '0 : r_tq[0];
                        r_out.tangent_y        <= r_degen ? '0 : r_tq[1];
                        r_out.tangent_z        <= r_degen ? '0 : r_tq[2];
                        r_out.bitangent_x      <= r_degen ? '0 : r_bq[0];
                        r_out.bitangent_y      <= r_degen ? '0 : r_bq[1];
                        r_out.bitangent_z      <= r_degen ? '0 : r_bq[2];
                        r_out.degenerate       <= r_degen;
                        r_out.last_of_triangle <= (r_k == 2'd2);
                        if (r_k == 2'd2) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
